// ===== design/snfcs_pkg.sv =====
// Shared types and constants of the serial NOR flash command sequencer.
package snfcs_pkg;

  localparam int MODE_W     = 3;
  localparam int ADDR_W     = 25;
  localparam int LEN_W      = 26;
  localparam int BYTE_W     = 8;
  localparam int CAP_W      = 26;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 26;

  localparam int MAX_RESULTS = 8;
  localparam int SLOT_IDX_W  = $clog2(MAX_RESULTS);
  localparam int SLOT_CNT_W  = SLOT_IDX_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CAP_W-1:0] CAP_MAX   = 26'h200_0000;
  localparam logic [CAP_W-1:0] CAP_RESET = 26'h100_0000;

  localparam int SECTOR_4K_BITS = 12;
  localparam int BLOCK_32K_BITS = 15;
  localparam int BLOCK_64K_BITS = 16;

  localparam logic [BYTE_W-1:0] CMD_WRITE_ENABLE = 8'h06;
  localparam logic [BYTE_W-1:0] CMD_PAGE_PROGRAM = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_READ_STATUS  = 8'h05;
  localparam logic [BYTE_W-1:0] CMD_READ_DATA    = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_ERASE_4K     = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_ERASE_32K    = 8'h52;
  localparam logic [BYTE_W-1:0] CMD_ERASE_64K    = 8'hD8;
  localparam logic [BYTE_W-1:0] CMD_ERASE_CHIP   = 8'hC7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDRESS_BYTES = 1'b0,
    CFG_CAPACITY      = 1'b1
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ       = 3'd0,
    MODE_WRITE      = 3'd1,
    MODE_ERASE_4K   = 3'd2,
    MODE_ERASE_32K  = 3'd3,
    MODE_ERASE_64K  = 3'd4,
    MODE_ERASE_CHIP = 3'd5,
    MODE_WRITE_BYTE = 3'd6,
    MODE_RECV_BYTE  = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ACT_SEND    = 3'd0,
    ACT_RECV    = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_DATA    = 3'd3,
    ACT_DONE    = 3'd4
  } act_t;

  typedef struct packed {
    act_t              action;
    logic [BYTE_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic [SLOT_CNT_W-1:0]   count;
    slot_t [MAX_RESULTS-1:0] slot;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== design/snfcs_ifs.sv =====
// Request and result channel interfaces of the command sequencer.
interface snfcs_req_if;
  import snfcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ADDR_W-1:0]   address;
  logic [LEN_W-1:0]    length;
  logic [BYTE_W-1:0]   write_byte;
  logic [BYTE_W-1:0]   received_byte;

  modport source (output valid, mode, address, length, write_byte, received_byte,
                  input ready);
  modport sink (input valid, mode, address, length, write_byte, received_byte,
                output ready);
endinterface

interface snfcs_res_if;
  import snfcs_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [BYTE_W-1:0] byte_value;
  logic              last;

  modport source (output valid, action, byte_value, last, input ready);
  modport sink (input valid, action, byte_value, last, output ready);
endinterface

// ===== design/serial_nor_flash_command_sequencer.sv =====
// Top level of the serial NOR flash command sequencer.
// Host-side sequencer for a serial NOR flash. Requests (read, write, erase) and the
// write and received bytes that follow them enter on in_req; SPI byte actions with
// select framing leave on out_res, one action per clock unless out_res stalls, the
// final action of each request flagged by last. The front end takes one request per
// clock while its two-entry queue has room and turns it into a list of up to eight
// actions; the back end drains that list through the output register at one action
// per clock while out_res.ready allows. PAGE_BYTES must be a power of two.
// Configuration is to be written through cfg_we, cfg_index and cfg_data only while
// no request is in flight; the user must keep to this, the block does not enforce it.
module serial_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  snfcs_req_if.sink                         in_req,
  snfcs_res_if.source                       out_res,
  input  logic                              cfg_we,
  input  logic [snfcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [snfcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import snfcs_pkg::*;

  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        head;
  queue_stat_t q_stat;

  snfcs_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  snfcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  snfcs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

// ===== design/snfcs_front.sv =====
// Front end: takes requests, tracks the flash phase and builds each request's action list.
module snfcs_front #(
  parameter int PAGE_BYTES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  snfcs_req_if.sink                           in_req,
  input  logic                                cfg_we,
  input  logic [snfcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [snfcs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  snfcs_pkg::queue_stat_t              q_stat,
  output logic                                push,
  output snfcs_pkg::job_t                     push_job
);
  import snfcs_pkg::*;

  localparam int PAGE_AW = $clog2(PAGE_BYTES);

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_READ       = 5'b00010,
    PH_WDATA      = 5'b00100,
    PH_POLL       = 5'b01000,
    PH_ERASE_WAIT = 5'b10000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [ADDR_W-1:0]  cur_r, cur_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic               addr4_r;
  logic [CAP_W-1:0]   cap_r;

  logic               accept;
  job_t               job_v;
  logic [CAP_W-1:0]   cap_eff;
  logic [LEN_W:0]     wend;
  logic [LEN_W:0]     wend_c;
  logic               wempty;
  logic [LEN_W-1:0]   wlen;
  logic [ADDR_W-1:0]  cur_inc;
  logic [LEN_W-1:0]   rem_dec;
  logic [ADDR_W-1:0]  erase_addr;

  function automatic job_t job_push(job_t j, act_t a, logic [BYTE_W-1:0] v);
    job_t r;
    r = j;
    r.slot[j.count[SLOT_IDX_W-1:0]] = '{action: a, value: v};
    r.count = j.count + SLOT_CNT_W'(1);
    return r;
  endfunction

  function automatic job_t job_addr(job_t j, logic [ADDR_W-1:0] a, logic four);
    job_t r;
    r = j;
    if (four) begin
      r = job_push(r, ACT_SEND, {7'b0, a[24]});
    end
    r = job_push(r, ACT_SEND, a[23:16]);
    r = job_push(r, ACT_SEND, a[15:8]);
    r = job_push(r, ACT_SEND, a[7:0]);
    return r;
  endfunction

  function automatic job_t job_page(job_t j, logic [ADDR_W-1:0] a, logic four);
    job_t r;
    r = job_push(j, ACT_SEND, CMD_WRITE_ENABLE);
    r = job_push(r, ACT_RELEASE, '0);
    r = job_push(r, ACT_SEND, CMD_PAGE_PROGRAM);
    r = job_addr(r, a, four);
    return r;
  endfunction

  assign in_req.ready = !q_stat.full;
  assign accept       = in_req.valid && in_req.ready;

  // clip the write window to the flash size
  assign cap_eff = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign wend    = {1'b0, in_req.length} + {2'b0, in_req.address};
  assign wend_c  = (wend > {1'b0, cap_eff}) ? {1'b0, cap_eff} : wend;
  assign wempty  = {2'b0, in_req.address} >= wend_c;
  assign wlen    = LEN_W'(wend_c - {2'b0, in_req.address});

  assign cur_inc = cur_r + ADDR_W'(1);
  assign rem_dec = rem_r - LEN_W'(1);

  always_comb begin
    unique case (mode_t'(in_req.mode))
      MODE_ERASE_4K:  erase_addr = {in_req.address[ADDR_W-1:SECTOR_4K_BITS],
                                    SECTOR_4K_BITS'(0)};
      MODE_ERASE_32K: erase_addr = {in_req.address[ADDR_W-1:BLOCK_32K_BITS],
                                    BLOCK_32K_BITS'(0)};
      default:        erase_addr = {in_req.address[ADDR_W-1:BLOCK_64K_BITS],
                                    BLOCK_64K_BITS'(0)};
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    job_v     = '0;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (mode_t'(in_req.mode))
          MODE_READ: begin
            cur_nxt = in_req.address;
            job_v   = job_push(job_v, ACT_SEND, CMD_READ_DATA);
            job_v   = job_addr(job_v, in_req.address, addr4_r);
            if (in_req.length == '0) begin
              job_v   = job_push(job_v, ACT_RELEASE, '0);
              job_v   = job_push(job_v, ACT_DONE, '0);
              rem_nxt = '0;
            end else begin
              job_v     = job_push(job_v, ACT_RECV, '0);
              rem_nxt   = in_req.length;
              phase_nxt = PH_READ;
            end
          end
          MODE_WRITE: begin
            if (wempty) begin
              job_v   = job_push(job_v, ACT_DONE, '0);
              rem_nxt = '0;
            end else begin
              cur_nxt   = in_req.address;
              rem_nxt   = wlen;
              job_v     = job_page(job_v, in_req.address, addr4_r);
              phase_nxt = PH_WDATA;
            end
          end
          MODE_ERASE_4K, MODE_ERASE_32K, MODE_ERASE_64K: begin
            rem_nxt = '0;
            job_v   = job_push(job_v, ACT_SEND, CMD_WRITE_ENABLE);
            job_v   = job_push(job_v, ACT_RELEASE, '0);
            unique case (mode_t'(in_req.mode))
              MODE_ERASE_4K:  job_v = job_push(job_v, ACT_SEND, CMD_ERASE_4K);
              MODE_ERASE_32K: job_v = job_push(job_v, ACT_SEND, CMD_ERASE_32K);
              default:        job_v = job_push(job_v, ACT_SEND, CMD_ERASE_64K);
            endcase
            job_v     = job_addr(job_v, erase_addr, addr4_r);
            job_v     = job_push(job_v, ACT_RELEASE, '0);
            phase_nxt = PH_ERASE_WAIT;
          end
          MODE_ERASE_CHIP: begin
            rem_nxt   = '0;
            job_v     = job_push(job_v, ACT_SEND, CMD_WRITE_ENABLE);
            job_v     = job_push(job_v, ACT_RELEASE, '0);
            job_v     = job_push(job_v, ACT_SEND, CMD_ERASE_CHIP);
            job_v     = job_push(job_v, ACT_RELEASE, '0);
            phase_nxt = PH_ERASE_WAIT;
          end
          default: begin
            job_v = '0;
          end
        endcase
      end
      PH_READ: begin
        if (mode_t'(in_req.mode) == MODE_RECV_BYTE) begin
          job_v = job_push(job_v, ACT_DATA, in_req.received_byte);
          if (rem_dec != '0) begin
            job_v   = job_push(job_v, ACT_RECV, '0);
            rem_nxt = rem_dec;
          end else begin
            job_v     = job_push(job_v, ACT_RELEASE, '0);
            job_v     = job_push(job_v, ACT_DONE, '0);
            rem_nxt   = '0;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_WDATA: begin
        if (mode_t'(in_req.mode) == MODE_WRITE_BYTE) begin
          job_v   = job_push(job_v, ACT_SEND, in_req.write_byte);
          rem_nxt = rem_dec;
          cur_nxt = cur_inc;
          // close the page at its edge or at the final byte
          if (cur_inc[PAGE_AW-1:0] == '0 || rem_dec == '0) begin
            job_v     = job_push(job_v, ACT_RELEASE, '0);
            job_v     = job_push(job_v, ACT_SEND, CMD_READ_STATUS);
            job_v     = job_push(job_v, ACT_RECV, '0);
            phase_nxt = PH_POLL;
          end
        end
      end
      PH_POLL: begin
        if (mode_t'(in_req.mode) == MODE_RECV_BYTE) begin
          job_v = job_push(job_v, ACT_RELEASE, '0);
          priority if (in_req.received_byte[0]) begin
            job_v = job_push(job_v, ACT_SEND, CMD_READ_STATUS);
            job_v = job_push(job_v, ACT_RECV, '0);
          end else if (rem_r != '0) begin
            job_v     = job_page(job_v, cur_r, addr4_r);
            phase_nxt = PH_WDATA;
          end else begin
            job_v     = job_push(job_v, ACT_DONE, '0);
            rem_nxt   = '0;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_ERASE_WAIT: begin
        if (mode_t'(in_req.mode) == MODE_RECV_BYTE) begin
          job_v     = job_push(job_v, ACT_SEND, CMD_READ_STATUS);
          job_v     = job_push(job_v, ACT_RECV, '0);
          phase_nxt = PH_POLL;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign push     = accept && (job_v.count != '0);
  assign push_job = job_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cur_r   <= '0;
      rem_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr4_r <= 1'b0;
      cap_r   <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ADDRESS_BYTES: addr4_r <= cfg_data[2];
        CFG_CAPACITY:      cap_r   <= cfg_data[CAP_W-1:0];
        default:           cap_r   <= cap_r;
      endcase
    end
  end

endmodule

// ===== design/snfcs_queue.sv =====
// Two-entry queue of action lists between the front and back ends.
module snfcs_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  snfcs_pkg::job_t        push_job,
  input  logic                   pop,
  output snfcs_pkg::job_t        head,
  output snfcs_pkg::queue_stat_t stat
);
  import snfcs_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full queue");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_head_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    !stat.empty |-> head.count != '0)
    else $error("queued action list is empty");

endmodule

// ===== design/snfcs_back.sv =====
// Back end: plays queued action lists into output register, one per clock unless stalled.
module snfcs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  snfcs_pkg::job_t        head,
  input  snfcs_pkg::queue_stat_t q_stat,
  output logic                   pop,
  snfcs_res_if.source            out_res
);
  import snfcs_pkg::*;

  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  act_t                  out_action_r;
  logic [BYTE_W-1:0]     out_value_r;
  logic                  out_last_r;

  logic  load;
  logic  last_now;
  slot_t cur_slot;

  assign load     = !q_stat.empty && (!out_valid_r || out_res.ready);
  assign cur_slot = head.slot[idx_r];
  assign last_now = ({1'b0, idx_r} + SLOT_CNT_W'(1)) == head.count;
  assign pop      = load && last_now;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last_now ? '0 : idx_r + SLOT_IDX_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_action_r <= cur_slot.action;
      out_value_r  <= cur_slot.value;
      out_last_r   <= last_now;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.action     = out_action_r;
  assign out_res.byte_value = out_value_r;
  assign out_res.last       = out_last_r;

endmodule
